>>> sv/tssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Term set subset matcher package
// Shared widths, request and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package tssm_pkg;

  localparam int TERM_W        = 16;
  localparam int DIM_W         = 5;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 7;
  localparam int OUT_DATA_W    = 16;

  // Highest usable dimension: the smaller of DIM and the term width.
  localparam int DIM           = 16;
  localparam int DIM_LIM       = (DIM < TERM_W) ? DIM : TERM_W;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  localparam int MAX_TERMS_DEF = 64;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONTAINED = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DOMINATED = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INDEP     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } seq_state_t;

endpackage

>>> sv/term_set_subset_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Term set subset matcher
// Table of bitset terms with clear, insert and subset dominance queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. in_tdata carries the term, in_tuser the request
//           kind and the strict flag. One request is taken while the
//           sequencer is idle; in_tready drops until that request is done.
//   out_* : one response per request from an output register.
//   cfg_* : dimension register, always ready; write it only while idle.
// Sequencing:
//   Insert and queries read each stored term once through one RAM read port
//   and one compare unit, then answer from the final state. Clear and unused
//   codes skip the scan and answer straight from the final state.
// Reset:
//   Empties the table (count and union cleared), sets dimension to 16 and
//   drops out_tvalid. The term RAM itself is not cleared; entries beyond the
//   count are never read.
// Back-pressure:
//   A response waits in the output register while out_tready is low; the
//   next request is still accepted and scanned, then holds in the final
//   state until the output register is free.
// ----------------------------------------------------------------------------
module term_set_subset_matcher
  import tssm_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TERM_W-1:0]     in_tdata,   // [15:0] query_term
  input  logic [3:0]            in_tuser,   // [2:0] req_type, [3] strict
  // response channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] hit, [7:1] count_now,
                                            // [8] degenerate, [10:9] status,
                                            // [15:11] zero
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DIM_W-1:0]      cfg_data    // [4:0] dimension
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  seq_state_t             state_r, state_nxt;
  logic [DIM_W-1:0]       dim_r, dim_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [TERM_W-1:0]      union_r, union_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [TERM_W-1:0]      q_r, q_nxt;
  logic [TERM_W-1:0]      mask_r, mask_nxt;
  logic                   strict_r, strict_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;
  logic                   found_r, found_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  // --------------------------------------------------------------------------
  // Combinational signals
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]       dim_eff;
  logic [TERM_W-1:0]      mask_now;
  logic                   in_acc;
  logic                   issue;
  logic                   out_free;
  logic                   fin_go;
  logic [TERM_W-1:0]      rd_data;
  logic [TERM_W-1:0]      t_m;
  logic                   sub_qt, sub_tq, eq, match;
  logic                   wr_en;
  logic                   hit;
  logic [STATUS_W-1:0]    status;
  logic                   degen;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign issue      = (state_r == S_SCAN) && (idx_r < n_r);
  assign fin_go     = (state_r == S_FIN) && out_free;

  // Clamp the dimension into 1..DIM_LIM and build its low-bit mask.
  always_comb begin
    if (dim_r == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_r > DIM_W'(DIM_LIM)) begin
      dim_eff = DIM_W'(DIM_LIM);
    end else begin
      dim_eff = dim_r;
    end
    for (int b = 0; b < TERM_W; b++) begin
      mask_now[b] = (DIM_W'(b) < dim_eff);
    end
  end

  // --------------------------------------------------------------------------
  // Term store: read one entry per scan cycle, append on insert
  // --------------------------------------------------------------------------
  tssm_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_TERMS)
  ) u_term_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (q_r),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Shared compare unit: stored term against the latched query
  // --------------------------------------------------------------------------
  always_comb begin
    t_m    = rd_data & mask_r;
    sub_qt = ((q_r & ~t_m) == '0);
    sub_tq = ((t_m & ~q_r) == '0);
    eq     = (t_m == q_r);
    case (req_r)
      REQ_INSERT:    match = eq;
      REQ_CONTAINED: match = sub_qt && (!strict_r || !eq);
      REQ_DOMINATED: match = sub_tq && (!strict_r || !eq);
      REQ_INDEP:     match = sub_qt || sub_tq;
      default:       match = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[2:0] inside {REQ_INSERT, REQ_CONTAINED, REQ_DOMINATED,
                                    REQ_INDEP}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        // The last compare lands in found_r on the same edge.
        if (!issue) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    dim_nxt        = dim_r;
    count_nxt      = count_r;
    union_nxt      = union_r;
    req_nxt        = req_r;
    q_nxt          = q_r;
    mask_nxt       = mask_r;
    strict_nxt     = strict_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    pend_nxt       = issue;
    found_nxt      = found_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    hit            = 1'b0;
    status         = ST_OK;

    if (cfg_valid && cfg_ready) begin
      dim_nxt = cfg_data;
    end

    // Latch the request and the mask in force for the whole scan.
    if (in_acc) begin
      req_nxt    = in_tuser[2:0];
      strict_nxt = in_tuser[3];
      q_nxt      = in_tdata & mask_now;
      mask_nxt   = mask_now;
      n_nxt      = count_r;
      idx_nxt    = '0;
      found_nxt  = 1'b0;
    end

    if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end

    // Accumulate the compare of the entry read last cycle.
    if (pend_r && match) begin
      found_nxt = 1'b1;
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (fin_go) begin
      case (req_r)
        REQ_CLEAR: begin
          count_nxt = '0;
          union_nxt = '0;
        end
        REQ_INSERT: begin
          if (found_r) begin
            status = ST_DUP;
          end else if (count_r >= CNT_MAX) begin
            status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            union_nxt = union_r | q_r;
          end
        end
        REQ_CONTAINED: hit = found_r;
        REQ_DOMINATED: hit = found_r;
        REQ_INDEP:     hit = !found_r;
        default:       hit = 1'b0;
      endcase
      degen          = (count_nxt == '0) || ((union_nxt & mask_r) != mask_r);
      cnt_ext        = {{COUNT_OUT_W{1'b0}}, count_nxt};
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'b0, status, degen, cnt_ext[COUNT_OUT_W-1:0], hit};
    end else begin
      degen   = 1'b0;
      cnt_ext = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Register update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_r        <= DIM_RESET;
      count_r      <= '0;
      union_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dim_r        <= dim_nxt;
      count_r      <= count_nxt;
      union_r      <= union_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload and scan working registers: no reset needed.
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    q_r         <= q_nxt;
    mask_r      <= mask_nxt;
    strict_r    <= strict_nxt;
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

>>> sv/tssm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
